/* hw/rtl/asp_pkg.sv */
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types and constants of the box sweep pair finder.
// ----------------------------------------------------------------------------
package asp_pkg;

    // Table and field sizes
    localparam int MAX_ENTRIES = 64;
    localparam int COORD_BITS  = 24;
    localparam int ID_BITS     = 16;
    localparam int IDX_BITS    = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);

    // One input beat: an actor's box
    typedef struct packed {
        logic [ID_BITS-1:0]           actor_id;
        logic                         active;
        logic                         movable;
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] max_z;
        logic                         frame_end;
    } in_item_t;

    // One result beat
    typedef struct packed {
        logic [ID_BITS-1:0] first_id;
        logic [ID_BITS-1:0] second_id;
        logic               table_full;
        logic               last_of_run;
    } out_item_t;

    // Stored table entry
    typedef struct packed {
        logic [ID_BITS-1:0]           id;
        logic signed [COORD_BITS-1:0] min_x;
        logic signed [COORD_BITS-1:0] min_y;
        logic signed [COORD_BITS-1:0] min_z;
        logic signed [COORD_BITS-1:0] max_x;
        logic signed [COORD_BITS-1:0] max_y;
        logic signed [COORD_BITS-1:0] max_z;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // latch new item, rewind scan
        logic read;      // read table at scan index, advance
        logic overflow;  // emit table-full result, end item
        logic finish;    // emit last pending pair, store item, end item
        logic drop;      // skipped item, end item
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic take;       // item is active and movable
        logic full;       // table holds MAX_ENTRIES boxes
        logic empty;      // table holds no box
        logic scan_last;  // current scan index is the last stored entry
    } dp_stat_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_FLUSH  = 5'b01000,
        ST_FINISH = 5'b10000
    } ctrl_state_t;

endpackage

/* hw/rtl/asp_ctrl.sv */
// ----------------------------------------------------------------------------
// asp_ctrl
// Sequencer: decides per item between skip, overflow, store and table scan.
// ----------------------------------------------------------------------------
module asp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  asp_pkg::dp_stat_t stat,
    output asp_pkg::dp_cmd_t  cmd
);
    import asp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!stat.take)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (stat.full)
                begin
                    cmd.overflow = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (stat.empty)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.read = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // last read entry is compared in this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

/* hw/rtl/asp_datapath.sv */
// ----------------------------------------------------------------------------
// asp_datapath
// Box table memory, overlap compare, pending pair and result register.
// ----------------------------------------------------------------------------
module asp_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  asp_pkg::in_item_t  item,
    input  asp_pkg::dp_cmd_t   cmd,
    output asp_pkg::dp_stat_t  stat,
    output logic               result_valid,
    output asp_pkg::out_item_t result
);
    import asp_pkg::*;

    entry_t              mem [MAX_ENTRIES];
    in_item_t            item_reg;
    entry_t              rd_data_reg;
    logic                rd_vld_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic [IDX_BITS-1:0] scan_idx_reg;
    out_item_t           pend_reg;
    logic                pend_vld_reg;
    out_item_t           out_reg;
    logic                out_vld_reg;
    logic                hit;
    out_item_t           pair;
    entry_t              wr_entry;

    // Status to controller
    assign stat.take      = item_reg.active & item_reg.movable;
    assign stat.full      = (count_reg == CNT_BITS'(MAX_ENTRIES));
    assign stat.empty     = (count_reg == '0);
    assign stat.scan_last = ((CNT_BITS'(scan_idx_reg) + CNT_BITS'(1)) == count_reg);

    // Item latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
    end

    // Table write and registered read
    assign wr_entry = '{id: item_reg.actor_id,
                        min_x: item_reg.min_x, min_y: item_reg.min_y,
                        min_z: item_reg.min_z, max_x: item_reg.max_x,
                        max_y: item_reg.max_y, max_z: item_reg.max_z};

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            mem[count_reg[IDX_BITS-1:0]] <= wr_entry;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    // Overlap test, inclusive on all three axes
    always_comb
    begin
        hit = ($signed(item_reg.min_x) <= $signed(rd_data_reg.max_x))
            && ($signed(rd_data_reg.min_x) <= $signed(item_reg.max_x))
            && ($signed(item_reg.min_y) <= $signed(rd_data_reg.max_y))
            && ($signed(rd_data_reg.min_y) <= $signed(item_reg.max_y))
            && ($signed(item_reg.min_z) <= $signed(rd_data_reg.max_z))
            && ($signed(rd_data_reg.min_z) <= $signed(item_reg.max_z));
        pair = '0;
        if ($signed(item_reg.min_x) < $signed(rd_data_reg.min_x))
        begin
            pair.first_id  = item_reg.actor_id;
            pair.second_id = rd_data_reg.id;
        end
        else
        begin
            pair.first_id  = rd_data_reg.id;
            pair.second_id = item_reg.actor_id;
        end
    end

    // Entry count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.finish)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        if ((cmd.finish || cmd.overflow || cmd.drop) && item_reg.frame_end)
        begin
            count_next = '0;
        end
    end

    // Control registers: count, scan index, read valid, pending flag, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_vld_reg <= cmd.read;
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.read)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_BITS'(1);
            end
            if (cmd.load || cmd.finish)
            begin
                pend_vld_reg <= 1'b0;
            end
            else if (rd_vld_reg && hit)
            begin
                pend_vld_reg <= 1'b1;
            end
            out_vld_reg <= cmd.overflow
                         | (cmd.finish & pend_vld_reg)
                         | (rd_vld_reg & hit & pend_vld_reg);
        end
    end

    // Pending pair and result payload; a pair leaves once the next one
    // or the end of the scan shows whether it is the last of the run
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && hit)
        begin
            pend_reg <= pair;
        end
        if (cmd.overflow)
        begin
            out_reg <= '{first_id: '0, second_id: '0,
                         table_full: 1'b1, last_of_run: 1'b1};
        end
        else if (cmd.finish)
        begin
            out_reg <= '{first_id: pend_reg.first_id, second_id: pend_reg.second_id,
                         table_full: 1'b0, last_of_run: 1'b1};
        end
        else if (rd_vld_reg && hit)
        begin
            out_reg <= pend_reg;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_read_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read |-> (CNT_BITS'(scan_idx_reg) < count_reg))
        else $error("scan read beyond stored entries");

    a_overflow_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.overflow |=> (result_valid && result.table_full && result.last_of_run
                          && result.first_id == '0 && result.second_id == '0))
        else $error("overflow beat malformed");

    a_pend_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !pend_vld_reg)
        else $error("pending pair left after item end");

    a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !stat.full)
        else $error("store into full table");

endmodule

/* hw/rtl/aabb_sweep_pair_finder.sv */
// ----------------------------------------------------------------------------
// aabb_sweep_pair_finder
// Broad-phase pair finder for 3-D axis-aligned boxes, top level.
// ----------------------------------------------------------------------------
// An actor is taken when start is high and busy is low. An active, movable
// actor is compared against the N boxes already stored in this frame, one
// stored box per cycle through the single read port of the box table, and
// then appended: busy stays high until the store. A skipped actor, an actor
// dropped on a full table and the first actor of a frame keep busy high for
// one cycle. Overlapping pairs come out in table order, at most one beat per
// cycle, each beat valid for the single cycle in which result_valid is high;
// the receiver cannot stall, so it must take every beat as it comes. The last
// beat of an actor carries last_of_run and may appear in the cycle after busy
// falls. frame_end clears the table after that actor's own work.
// ----------------------------------------------------------------------------
module aabb_sweep_pair_finder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  asp_pkg::in_item_t  item,
    output logic               result_valid,
    output asp_pkg::out_item_t result
);
    import asp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    asp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Table, compare and result path
    asp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
